### hw/rtl/qcv_pkg.sv
// Shared types, widths and codes for the quadrature counter with velocity.
// Used by every module under hw/rtl; depends on nothing else.
package qcv_pkg;

	// Field and state widths
	localparam int CNT_W   = 32;
	localparam int TICK_W  = 32;
	localparam int RATE_W  = 40;
	localparam int PPR_W   = 15;
	localparam int CPR_W   = PPR_W + 2;
	localparam int DELTA_W = 3;

	// Tick rate and the Q8 scale applied to a count difference
	localparam int    TICKS_PER_SECOND = 1000000;
	localparam longint RATE_SCALE      = longint'(TICKS_PER_SECOND) * 256;
	localparam int    SCALE_W          = $clog2(RATE_SCALE + 1);
	localparam logic [SCALE_W-1:0] SCALE_C = SCALE_W'(RATE_SCALE);

	// Divider sizing: numerator is |dN| * scale, divisor is a 33-bit tick span
	localparam int NUM_W = CNT_W + SCALE_W;
	localparam int DEN_W = TICK_W + 1;
	localparam int DT_W  = TICK_W + 3;
	localparam int QR_W  = NUM_W + 1;
	localparam int M_W   = CNT_W + 1;

	localparam logic [RATE_W-1:0] RATE_MAX = {1'b0, {(RATE_W-1){1'b1}}};
	localparam logic [RATE_W-1:0] RATE_MIN = {1'b1, {(RATE_W-1){1'b0}}};

	localparam logic signed [DELTA_W-1:0] DELTA_UP   = DELTA_W'(1);
	localparam logic signed [DELTA_W-1:0] DELTA_DOWN = -DELTA_W'(1);
	localparam logic signed [DELTA_W-1:0] DELTA_ZERO = DELTA_W'(0);

	// Configuration port
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	// Queue between front and back
	localparam int QDEPTH = 2;

	typedef enum logic [1:0] {
		MODE_NONE   = 2'd0,
		MODE_SAMPLE = 2'd1,
		MODE_CLEAR  = 2'd2,
		MODE_REBASE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REG_QUAD  = 2'd0,
		REG_INDEX = 2'd1,
		REG_PPR   = 2'd2,
		REG_STALL = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic              quad_enable;
		logic              index_enable;
		logic [PPR_W-1:0]  pulses_per_rev;
		logic [TICK_W-1:0] stall_ticks;
	} cfg_t;

	// One classified tick as it travels from front to back
	typedef struct packed {
		logic signed [DELTA_W-1:0] delta;
		logic                      moved;
		logic                      index_rise;
		cmd_t                      cmd;
		logic [TICK_W-1:0]         tick;
	} item_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] quo;
		logic [DEN_W-1:0] rem;
	} div_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MODE,
		ST_RSTART,
		ST_RDIV,
		ST_RFIX,
		ST_RADJ,
		ST_VPREP,
		ST_VMUL,
		ST_VSTART,
		ST_VDIV,
		ST_VEND
	} back_state_t;

endpackage

### hw/rtl/qcv_front.sv
// Front end: takes sampled pin words, finds A/B/index edges, stamps the tick.
// Depends on qcv_pkg.
module qcv_front import qcv_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       sample_valid,
	output logic       sample_ready,
	input  logic       chan_a,
	input  logic       chan_b,
	input  logic       chan_index,
	input  logic [1:0] mode,
	input  logic       q_full,
	output logic       push,
	output item_t      push_item
);

	logic                      last_a_q;
	logic                      last_b_q;
	logic                      last_index_q;
	logic [TICK_W-1:0]         tick_q;
	logic                      chg_a;
	logic                      chg_b;
	logic                      up;
	logic                      down;
	logic signed [DELTA_W-1:0] step_a;
	logic signed [DELTA_W-1:0] step_b;

	assign sample_ready = !q_full;
	assign push         = sample_valid && !q_full;

	always_comb begin
		chg_a = chan_a != last_a_q;
		chg_b = chan_b != last_b_q;
		// B direction is judged against the new A level
		step_a = (last_a_q == last_b_q) ? DELTA_UP : DELTA_DOWN;
		step_b = (chan_a != last_b_q) ? DELTA_UP : DELTA_DOWN;
		up     = chan_a && !last_a_q && !chan_b;
		down   = chan_b && !last_b_q && !chan_a;

		if (cfg.quad_enable) begin
			push_item.delta = (chg_a ? step_a : DELTA_ZERO) + (chg_b ? step_b : DELTA_ZERO);
			push_item.moved = chg_a || chg_b;
		end else begin
			push_item.delta = up ? DELTA_UP : (down ? DELTA_DOWN : DELTA_ZERO);
			push_item.moved = up || down;
		end
		push_item.index_rise = cfg.index_enable && chan_index && !last_index_q;
		push_item.cmd        = cmd_t'(mode);
		push_item.tick       = tick_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_a_q     <= 1'b0;
			last_b_q     <= 1'b0;
			last_index_q <= 1'b0;
			tick_q       <= '0;
		end else if (push) begin
			last_a_q     <= chan_a;
			last_b_q     <= chan_b;
			last_index_q <= chan_index;
			tick_q       <= tick_q + 1'b1;
		end
	end

endmodule

### hw/rtl/qcv_queue.sv
// Short queue of classified ticks between the front and back ends.
// Depends on qcv_pkg.
module qcv_queue import qcv_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output item_t head,
	output logic  not_empty
);

	localparam int PTR_W = $clog2(QDEPTH);

	item_t            mem_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   fill_q;

	assign full      = fill_q == (PTR_W+1)'(QDEPTH);
	assign not_empty = fill_q != '0;
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue written while full");
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n) pop |-> not_empty)
		else $error("queue read while empty");
`endif

endmodule

### hw/rtl/qcv_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Serves index rounding and the velocity quotient. Depends on qcv_pkg.
module qcv_div import qcv_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int STEP_W = $clog2(NUM_W);

	logic [NUM_W-1:0]  acc_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [DEN_W:0]    trial;
	logic [DEN_W:0]    diff;
	logic              ge;

	always_comb begin
		trial = {rem_q, acc_q[NUM_W-1]};
		diff  = trial - {1'b0, den_q};
		ge    = !diff[DEN_W];
	end

	assign rsp.done = done_q;
	assign rsp.quo  = acc_q;
	assign rsp.rem  = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= STEP_W'(NUM_W - 1);
		end else if (busy_q) begin
			if (step_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				step_q <= step_q - 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Numerator bits leave at the top of acc_q while quotient bits enter below
	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			acc_q <= {acc_q[NUM_W-2:0], ge};
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

`ifndef SYNTHESIS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> (!busy_q && req.den != '0))
		else $error("divider started while busy or with a zero divisor");
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (rem_q < den_q))
		else $error("divider remainder not below divisor");
`endif

endmodule

### hw/rtl/qcv_back.sv
// Back end: applies edges, index alignment and commands to the count state,
// computes velocity samples and holds the result word. Depends on qcv_pkg.
module qcv_back import qcv_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfg_t                     cfg,
	input  logic                     q_valid,
	input  item_t                    head,
	output logic                     pop,
	output div_req_t                 div_req,
	input  div_rsp_t                 div_rsp,
	output logic                     result_valid,
	input  logic                     result_ready,
	output logic signed [CNT_W-1:0]  position_count,
	output logic signed [RATE_W-1:0] pulse_rate,
	output logic                     index_found,
	output logic signed [CNT_W-1:0]  index_offset
);

	localparam logic [QR_W-1:0] RATE_POS_LIM = QR_W'(RATE_MAX);
	localparam logic [QR_W-1:0] RATE_NEG_LIM = RATE_POS_LIM + QR_W'(1);

	back_state_t state_q, state_d;

	// Architectural state
	logic signed [CNT_W-1:0]  cnt_q, cnt_d;
	logic signed [CNT_W-1:0]  fic_q, fic_d;
	logic signed [CNT_W-1:0]  cas_q, cas_d;
	logic [TICK_W-1:0]        let_q, let_d;
	logic [TICK_W-1:0]        lst_q, lst_d;
	logic [TICK_W-1:0]        held_q, held_d;
	logic signed [RATE_W-1:0] rate_q, rate_d;

	// Working registers for the word in hand
	cmd_t                     cmd_q, cmd_d;
	logic [TICK_W-1:0]        tick_q, tick_d;
	logic                     neg_q, neg_d;
	logic [CNT_W-1:0]         mag_q, mag_d;
	logic [M_W-1:0]           m_q, m_d;
	logic signed [CNT_W-1:0]  adj_q, adj_d;
	logic [TICK_W-1:0]        ts_q, ts_d;
	logic [TICK_W-1:0]        th_q, th_d;
	logic signed [CNT_W-1:0]  dn_q, dn_d;
	logic signed [DT_W-1:0]   dt_q, dt_d;
	logic                     stall_q, stall_d;
	logic                     ok_q, ok_d;
	logic [NUM_W-1:0]         prod_q, prod_d;
	logic [QR_W-1:0]          qr_q, qr_d;

	logic                     out_valid_q;
	logic                     out_free;
	logic                     load;
	logic [CNT_W-1:0]         cnt_u;
	logic [CNT_W-1:0]         dn_u;
	logic [CNT_W-1:0]         mag_cnt;
	logic [CNT_W-1:0]         mag_dn;
	logic [CPR_W-1:0]         cpr;
	logic                     round_r;
	logic                     round_v;
	logic [CNT_W-1:0]         m_lo;
	logic signed [CNT_W-1:0]  newc;
	logic [QR_W-1:0]          qr_lim;
	logic [RATE_W-1:0]        qr_rate;
	logic signed [RATE_W-1:0] sat_rate;

	assign out_free     = !out_valid_q || result_ready;
	assign result_valid = out_valid_q;

	assign cnt_u   = cnt_q;
	assign dn_u    = dn_q;
	assign mag_cnt = cnt_q[CNT_W-1] ? ('0 - cnt_u) : cnt_u;
	assign mag_dn  = dn_q[CNT_W-1] ? ('0 - dn_u) : dn_u;
	assign cpr     = cfg.quad_enable ? {cfg.pulses_per_rev, 2'b00} : CPR_W'(cfg.pulses_per_rev);
	assign round_r = {div_rsp.rem, 1'b0} >= (DEN_W+1)'(cpr);
	assign round_v = {div_rsp.rem, 1'b0} >= {1'b0, dt_q[DEN_W-1:0]};
	assign m_lo    = m_q[CNT_W-1:0];
	assign newc    = neg_q ? -$signed(m_lo) : $signed(m_lo);
	assign qr_lim  = neg_q ? RATE_NEG_LIM : RATE_POS_LIM;
	assign qr_rate = qr_q[RATE_W-1:0];
	assign sat_rate = (qr_q > qr_lim) ? (neg_q ? RATE_MIN : RATE_MAX)
	                                  : (neg_q ? ('0 - qr_rate) : qr_rate);

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		load    = 1'b0;
		div_req = '0;
		cnt_d   = cnt_q;
		fic_d   = fic_q;
		cas_d   = cas_q;
		let_d   = let_q;
		lst_d   = lst_q;
		held_d  = held_q;
		rate_d  = rate_q;
		cmd_d   = cmd_q;
		tick_d  = tick_q;
		neg_d   = neg_q;
		mag_d   = mag_q;
		m_d     = m_q;
		adj_d   = adj_q;
		ts_d    = ts_q;
		th_d    = th_q;
		dn_d    = dn_q;
		dt_d    = dt_q;
		stall_d = stall_q;
		ok_d    = ok_q;
		prod_d  = prod_q;
		qr_d    = qr_q;

		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					pop    = 1'b1;
					cnt_d  = cnt_q + CNT_W'($signed(head.delta));
					cmd_d  = head.cmd;
					tick_d = head.tick;
					if (head.moved) begin
						let_d = head.tick;
					end
					if (head.index_rise && fic_q != '0) begin
						state_d = ST_RSTART;
					end else begin
						if (head.index_rise) begin
							fic_d = cnt_d;
						end
						state_d = ST_MODE;
					end
				end
			end
			ST_RSTART: begin
				neg_d = cnt_q[CNT_W-1];
				mag_d = mag_cnt;
				if (cpr == '0) begin
					state_d = ST_MODE;
				end else begin
					div_req.start = 1'b1;
					div_req.num   = NUM_W'(mag_cnt);
					div_req.den   = DEN_W'(cpr);
					state_d       = ST_RDIV;
				end
			end
			ST_RDIV: begin
				if (div_rsp.done) begin
					// Nearest multiple of cpr: |count| - remainder, plus cpr when rounding up
					m_d = M_W'(mag_q) - M_W'(div_rsp.rem) + (round_r ? M_W'(cpr) : M_W'(0));
					state_d = ST_RFIX;
				end
			end
			ST_RFIX: begin
				cnt_d   = newc;
				adj_d   = newc - cnt_q;
				state_d = ST_RADJ;
			end
			ST_RADJ: begin
				cas_d   = cas_q + adj_q;
				state_d = ST_MODE;
			end
			ST_MODE: begin
				unique case (cmd_q)
					MODE_SAMPLE: begin
						ts_d    = tick_q - lst_q;
						th_d    = tick_q - let_q;
						dn_d    = cnt_q - cas_q;
						state_d = ST_VPREP;
					end
					MODE_CLEAR: begin
						if (out_free) begin
							cnt_d   = '0;
							let_d   = tick_q;
							load    = 1'b1;
							state_d = ST_IDLE;
						end
					end
					MODE_REBASE: begin
						if (out_free) begin
							cnt_d   = cnt_q - fic_q;
							cas_d   = cnt_d;
							load    = 1'b1;
							state_d = ST_IDLE;
						end
					end
					MODE_NONE: begin
						if (out_free) begin
							load    = 1'b1;
							state_d = ST_IDLE;
						end
					end
				endcase
			end
			ST_VPREP: begin
				dt_d    = DT_W'(ts_q) + DT_W'(held_q) - DT_W'(th_q);
				neg_d   = dn_q[CNT_W-1];
				mag_d   = mag_dn;
				stall_d = th_q > cfg.stall_ticks;
				lst_d   = tick_q;
				held_d  = th_q;
				cas_d   = cnt_q;
				state_d = ST_VMUL;
			end
			ST_VMUL: begin
				prod_d  = NUM_W'(mag_q) * NUM_W'(SCALE_C);
				ok_d    = (dn_q != '0) && ($signed({dt_q, 1'b0}) > $signed((DT_W+1)'(ts_q)));
				state_d = ok_d ? ST_VSTART : ST_VEND;
			end
			ST_VSTART: begin
				div_req.start = 1'b1;
				div_req.num   = prod_q;
				div_req.den   = dt_q[DEN_W-1:0];
				state_d       = ST_VDIV;
			end
			ST_VDIV: begin
				if (div_rsp.done) begin
					qr_d    = QR_W'(div_rsp.quo) + QR_W'(round_v);
					state_d = ST_VEND;
				end
			end
			ST_VEND: begin
				if (out_free) begin
					if (stall_q) begin
						rate_d = '0;
					end else if (ok_q) begin
						rate_d = sat_rate;
					end
					load    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			fic_q       <= '0;
			cas_q       <= '0;
			let_q       <= '0;
			lst_q       <= '0;
			held_q      <= '0;
			rate_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			cnt_q  <= cnt_d;
			fic_q  <= fic_d;
			cas_q  <= cas_d;
			let_q  <= let_d;
			lst_q  <= lst_d;
			held_q <= held_d;
			rate_q <= rate_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cmd_q   <= cmd_d;
		tick_q  <= tick_d;
		neg_q   <= neg_d;
		mag_q   <= mag_d;
		m_q     <= m_d;
		adj_q   <= adj_d;
		ts_q    <= ts_d;
		th_q    <= th_d;
		dn_q    <= dn_d;
		dt_q    <= dt_d;
		stall_q <= stall_d;
		ok_q    <= ok_d;
		prod_q  <= prod_d;
		qr_q    <= qr_d;
		if (load) begin
			position_count <= cnt_d;
			pulse_rate     <= rate_d;
			index_found    <= fic_d != '0;
			index_offset   <= fic_d;
		end
	end

`ifndef SYNTHESIS
	a_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_RDIV || state_q == ST_VDIV))
		else $error("divider finished with no division pending");
	a_stall_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_VEND && stall_q && out_free) |=> (pulse_rate == '0))
		else $error("stalled sample did not zero the rate");
`endif

endmodule

### hw/rtl/quadrature_counter_with_velocity.sv
// Top level of the quadrature counter with index alignment and velocity.
// Holds the APB registers and joins front end, queue, divider and back end.
// Depends on qcv_pkg, qcv_front, qcv_queue, qcv_div and qcv_back.
//
// Each accepted word is one tick of sampled A, B and index levels plus a
// command (none, velocity sample, clear count, rebase to index). The front
// end takes a word in any cycle the two-word queue has room, detects edges
// (4x in quadrature mode, single rising edges otherwise) and stamps the tick
// number; the back end drains the queue and answers every word with one
// result word: position count, rate in counts per second (signed Q8,
// saturating, zero once the last edge is older than stall_ticks), index
// found flag and the count recorded at the first index edge. A plain tick
// passes through the idle and mode states of the back end. A later index
// edge rounds the count to the nearest revolution through the shared
// 60-step restoring divider; a velocity sample goes through a 32x28
// multiply and the same divider. The queue lets the pin side keep
// delivering words while the back end works. Write configuration only
// while the block is idle. Registers sit at byte addresses 0 (quad_enable),
// 4 (index_enable), 8 (pulses_per_rev) and 12 (stall_ticks), and read
// back the stored field, zero-extended.
module quadrature_counter_with_velocity import qcv_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	// APB configuration port
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [PADDR_W-1:0]       paddr,
	input  logic [PDATA_W-1:0]       pwdata,
	output logic [PDATA_W-1:0]       prdata,
	output logic                     pready,
	// Tick words
	input  logic                     sample_valid,
	output logic                     sample_ready,
	input  logic                     chan_a,
	input  logic                     chan_b,
	input  logic                     chan_index,
	input  logic [1:0]               mode,
	// Result words
	output logic                     result_valid,
	input  logic                     result_ready,
	output logic signed [CNT_W-1:0]  position_count,
	output logic signed [RATE_W-1:0] pulse_rate,
	output logic                     index_found,
	output logic signed [CNT_W-1:0]  index_offset
);

	cfg_t     cfg_q;
	reg_idx_t reg_sel;
	logic     wr_en;
	logic     push;
	logic     pop;
	logic     q_full;
	logic     q_valid;
	item_t    push_item;
	item_t    head;
	div_req_t div_req;
	div_rsp_t div_rsp;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_sel = reg_idx_t'(paddr[3:2]);

	// Register file: write on the access phase, reset to the documented defaults
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.quad_enable    <= 1'b1;
			cfg_q.index_enable   <= 1'b0;
			cfg_q.pulses_per_rev <= PPR_W'(1024);
			cfg_q.stall_ticks    <= TICK_W'(150000);
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_QUAD:  cfg_q.quad_enable    <= pwdata[0];
				REG_INDEX: cfg_q.index_enable   <= pwdata[0];
				REG_PPR:   cfg_q.pulses_per_rev <= pwdata[PPR_W-1:0];
				REG_STALL: cfg_q.stall_ticks    <= pwdata[TICK_W-1:0];
			endcase
		end
	end

	// Read back the addressed register, zero-extended
	always_comb begin
		unique case (reg_sel)
			REG_QUAD:  prdata = PDATA_W'(cfg_q.quad_enable);
			REG_INDEX: prdata = PDATA_W'(cfg_q.index_enable);
			REG_PPR:   prdata = PDATA_W'(cfg_q.pulses_per_rev);
			REG_STALL: prdata = PDATA_W'(cfg_q.stall_ticks);
		endcase
	end

	// Classify pin levels and stamp the tick
	qcv_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.chan_a       (chan_a),
		.chan_b       (chan_b),
		.chan_index   (chan_index),
		.mode         (mode),
		.q_full       (q_full),
		.push         (push),
		.push_item    (push_item)
	);

	// Decouple the pin side from the arithmetic
	qcv_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.head      (head),
		.not_empty (q_valid)
	);

	// One divider shared by index rounding and velocity
	qcv_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Count state, commands, velocity and the result register
	qcv_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.q_valid        (q_valid),
		.head           (head),
		.pop            (pop),
		.div_req        (div_req),
		.div_rsp        (div_rsp),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.position_count (position_count),
		.pulse_rate     (pulse_rate),
		.index_found    (index_found),
		.index_offset   (index_offset)
	);

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for quadrature_counter_with_velocity: directed and random tick words,
// checked word by word against a count, index and velocity tracker held in a class.
// Depends on qcv_pkg and the RTL under hw/rtl; nothing else.

class count_tracker;
	typedef struct {
		int                                  position;
		logic signed [qcv_pkg::RATE_W-1:0]   rate;
		bit                                  found;
		int                                  offset;
	} readout_t;

	// register copies
	bit          quad_en;
	bit          index_en;
	int unsigned ppr;
	int unsigned stall;

	// encoder state
	bit          lvl_a, lvl_b, lvl_ix;
	int          count, index_count, base_count;
	int unsigned now_tick, edge_tick, sample_tick, held_ticks;
	longint      rate;

	readout_t    due_readouts[$];
	int          miss_count;

	function new();
		quad_en  = 1'b1;
		index_en = 1'b0;
		ppr      = 1024;
		stall    = 150000;
	endfunction

	function void report_miss(string what);
		$display("[mismatch] %s", what);
		miss_count++;
	endfunction

	function void set_reg(qcv_pkg::reg_idx_t idx, logic [31:0] value);
		case (idx)
			qcv_pkg::REG_QUAD:  quad_en = value[0];
			qcv_pkg::REG_INDEX: index_en = value[0];
			qcv_pkg::REG_PPR:   ppr = 32'(value[14:0]);
			default:            stall = value;
		endcase
	endfunction

	// nearest multiple of a revolution, halves away from zero
	function int round_to_rev(int c, int unsigned cpr);
		longint          wide;
		longint unsigned mag, q;
		if (cpr == 0)
			return c;
		wide = c;
		mag = (wide < 0) ? -wide : wide;
		q = mag / cpr;
		if (2 * (mag % cpr) >= cpr)
			q++;
		return (wide < 0) ? int'(-(q * cpr)) : int'(q * cpr);
	endfunction

	// counts per second in Q8, rounded half away from zero, saturated to 40 bits
	function longint rate_for(int diff, longint span);
		longint          wide;
		longint unsigned num, q, r, lim;
		wide = diff;
		num = ((wide < 0) ? -wide : wide) * qcv_pkg::RATE_SCALE;
		q = num / span;
		r = num % span;
		if (2 * r >= span)
			q++;
		lim = (wide < 0) ? (64'd1 << 39) : ((64'd1 << 39) - 1);
		if (q > lim)
			q = lim;
		return (wide < 0) ? -longint'(q) : longint'(q);
	endfunction

	function void note_tick(bit a, bit b, bit ix, qcv_pkg::cmd_t cmd);
		int unsigned now, cpr, span_s, span_e;
		int          prev, diff;
		longint      span;
		readout_t    w;
		now = now_tick;
		cpr = quad_en ? 4 * ppr : ppr;

		if (quad_en) begin
			if (a != lvl_a) begin
				count += (lvl_a == lvl_b) ? 1 : -1;
				edge_tick = now;
				lvl_a = a;
			end
			if (b != lvl_b) begin
				count += (lvl_a != lvl_b) ? 1 : -1;
				edge_tick = now;
				lvl_b = b;
			end
		end else begin
			if (a && !lvl_a && !b) begin
				count++;
				edge_tick = now;
			end
			if (b && !lvl_b && !a) begin
				count--;
				edge_tick = now;
			end
			lvl_a = a;
			lvl_b = b;
		end

		if (index_en && ix && !lvl_ix) begin
			if (index_count != 0) begin
				prev = count;
				count = round_to_rev(count, cpr);
				base_count = base_count + count - prev;
			end else begin
				index_count = count;
			end
		end
		lvl_ix = ix;

		case (cmd)
			qcv_pkg::MODE_SAMPLE: begin
				span_s = now - sample_tick;
				span_e = now - edge_tick;
				diff = count - base_count;
				span = longint'(span_s) + longint'(held_ticks) - longint'(span_e);
				if (diff != 0 && 2 * span > longint'(span_s))
					rate = rate_for(diff, span);
				if (span_e > stall)
					rate = 0;
				sample_tick = now;
				held_ticks = span_e;
				base_count = count;
			end
			qcv_pkg::MODE_CLEAR: begin
				count = 0;
				edge_tick = now;
			end
			qcv_pkg::MODE_REBASE: begin
				count = count - index_count;
				base_count = count;
			end
			default: ;
		endcase
		now_tick = now + 1;

		w.position = count;
		w.rate     = rate[qcv_pkg::RATE_W-1:0];
		w.found    = (index_count != 0);
		w.offset   = index_count;
		due_readouts.push_back(w);
	endfunction

	function void check_result(logic signed [31:0] pos, logic signed [qcv_pkg::RATE_W-1:0] rt,
			logic found, logic signed [31:0] off);
		readout_t w;
		if (due_readouts.size() == 0) begin
			report_miss("result word with nothing expected");
			return;
		end
		w = due_readouts.pop_front();
		if (pos !== w.position)
			report_miss($sformatf("position_count %0d, expected %0d", pos, w.position));
		if (rt !== w.rate)
			report_miss($sformatf("pulse_rate %0d, expected %0d", rt, w.rate));
		if (found !== w.found)
			report_miss($sformatf("index_found %0b, expected %0b", found, w.found));
		if (off !== w.offset)
			report_miss($sformatf("index_offset %0d, expected %0d", off, w.offset));
	endfunction
endclass

module tb_top;
	import qcv_pkg::*;

	localparam int GAP_MAX       = 14;
	// longest quiet stretch: sender gap, two queued words plus one in the back end,
	// receiver stall and the settle pause, with a wide margin
	localparam int QUIET_LIMIT   = 3000;
	localparam int SETTLE_CYCLES = 100;
	localparam int RANDOM_TICKS  = 950;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     psel = 1'b0;
	logic                     penable = 1'b0;
	logic                     pwrite = 1'b0;
	logic [PADDR_W-1:0]       paddr = '0;
	logic [PDATA_W-1:0]       pwdata = '0;
	logic [PDATA_W-1:0]       prdata;
	logic                     pready;
	logic                     sample_valid = 1'b0;
	logic                     sample_ready;
	logic                     chan_a = 1'b0;
	logic                     chan_b = 1'b0;
	logic                     chan_index = 1'b0;
	logic [1:0]               mode = MODE_NONE;
	logic                     result_valid;
	logic                     result_ready = 1'b0;
	logic signed [CNT_W-1:0]  position_count;
	logic signed [RATE_W-1:0] pulse_rate;
	logic                     index_found;
	logic signed [CNT_W-1:0]  index_offset;

	count_tracker tracker = new();

	// levels last handed to the block, so that holds and steps start from them
	bit cur_a, cur_b, cur_ix;
	bit src_calm, snk_calm;
	int ticks_sent;
	int quiet_cycles = 0;

	quadrature_counter_with_velocity u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.sample_valid   (sample_valid),
		.sample_ready   (sample_ready),
		.chan_a         (chan_a),
		.chan_b         (chan_b),
		.chan_index     (chan_index),
		.mode           (mode),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.position_count (position_count),
		.pulse_rate     (pulse_rate),
		.index_found    (index_found),
		.index_offset   (index_offset)
	);

	always #5 clk = ~clk;

	// Draw the idle cycles before the next word; now and then flip into or out of a
	// calm stretch in which this side does not idle.
	function automatic int draw_gap(inout bit calm);
		if ($urandom_range(0, 39) == 0)
			calm = !calm;
		return calm ? 0 : $urandom_range(0, GAP_MAX);
	endfunction

	// Offer one tick word after a random gap and hold it until the block takes it.
	task automatic tick(bit a, bit b, bit ix, cmd_t cmd);
		int gap;
		gap = draw_gap(src_calm);
		if (gap > 0) begin
			@(negedge clk);
			sample_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		sample_valid <= 1'b1;
		chan_a       <= a;
		chan_b       <= b;
		chan_index   <= ix;
		mode         <= cmd;
		do @(posedge clk); while (sample_ready !== 1'b1);
		tracker.note_tick(a, b, ix, cmd);
		cur_a  = a;
		cur_b  = b;
		cur_ix = ix;
		ticks_sent++;
	endtask

	// Advance the encoder a quarter cycle; forward runs 00, 10, 11, 01 and counts up.
	task automatic step(bit fwd, bit ix, cmd_t cmd);
		int phase;
		phase = cur_a ? (cur_b ? 2 : 1) : (cur_b ? 3 : 0);
		phase = (phase + (fwd ? 1 : 3)) % 4;
		tick(phase == 1 || phase == 2, phase == 2 || phase == 3, ix, cmd);
	endtask

	// Drop valid, wait for every outstanding result word, then let the back end go quiet.
	task automatic settle();
		@(negedge clk);
		sample_valid <= 1'b0;
		while (tracker.due_readouts.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'({idx, 2'b00});
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		tracker.set_reg(idx, value);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic configure(bit quad, bit use_index, logic [14:0] ppr, logic [31:0] stall);
		settle();
		write_reg(REG_QUAD, {31'd0, quad});
		write_reg(REG_INDEX, {31'd0, use_index});
		write_reg(REG_PPR, {17'd0, ppr});
		write_reg(REG_STALL, stall);
	endtask

	task automatic directed_ticks();
		// Reset settings: 4x counting, index channel unused but still tracked
		tick(1, 0, 0, MODE_NONE);
		tick(1, 1, 0, MODE_NONE);
		tick(0, 1, 0, MODE_SAMPLE);
		tick(0, 0, 1, MODE_NONE);
		tick(1, 1, 0, MODE_SAMPLE);      // both levels jump in one tick
		tick(0, 1, 1, MODE_NONE);
		tick(0, 1, 0, MODE_CLEAR);
		tick(0, 1, 0, MODE_REBASE);
		tick(0, 1, 0, MODE_SAMPLE);

		// Single edges, index used, three counts a turn, stall after one tick
		configure(1'b0, 1'b1, 15'd3, 32'd1);
		tick(0, 0, 0, MODE_CLEAR);
		tick(0, 0, 1, MODE_NONE);        // first index edge at zero leaves it not found
		tick(1, 0, 0, MODE_NONE);
		tick(0, 0, 0, MODE_NONE);
		tick(1, 0, 1, MODE_NONE);        // now records a nonzero offset
		tick(1, 1, 0, MODE_NONE);        // B rising with A high: no count
		tick(0, 0, 0, MODE_NONE);
		tick(0, 1, 0, MODE_NONE);
		tick(1, 0, 1, MODE_SAMPLE);      // later index edge rounds to the turn
		tick(1, 0, 0, MODE_SAMPLE);
		tick(1, 0, 0, MODE_SAMPLE);      // last edge older than the stall: zero rate
		tick(1, 0, 0, MODE_REBASE);

		// Zero pulses per turn: rounding leaves the count alone
		configure(1'b1, 1'b1, 15'd0, 32'hFFFF_FFFF);
		tick(0, 0, 0, MODE_NONE);
		tick(0, 0, 1, MODE_NONE);
		tick(0, 1, 0, MODE_SAMPLE);

		// Widest pulse count the field holds, stall of zero ticks
		configure(1'b1, 1'b1, 15'h7FFF, 32'd0);
		tick(0, 1, 1, MODE_SAMPLE);
		tick(1, 1, 0, MODE_REBASE);
	endtask

	// Double the count through index rounding until a drop to zero over two ticks
	// drives the rate into saturation; forward ends at the negative limit.
	task automatic spin_up(bit fwd);
		int mag;
		configure(1'b1, 1'b1, 15'd2, 32'hFFFF_FFFF);
		tick(cur_a, cur_b, 1'b0, MODE_CLEAR);
		repeat (8) step(fwd, 1'b0, MODE_NONE);
		mag = (tracker.count < 0) ? -tracker.count : tracker.count;
		for (int i = 0; i < 16 && mag > 0 && mag < 8192; i++) begin
			// a turn of twice the count puts the count exactly halfway: round away
			configure(1'b1, 1'b1, 15'(mag / 2), 32'hFFFF_FFFF);
			tick(cur_a, cur_b, 1'b1, MODE_NONE);
			tick(cur_a, cur_b, 1'b0, MODE_NONE);
			mag = (tracker.count < 0) ? -tracker.count : tracker.count;
		end
		step(fwd, 1'b0, MODE_NONE);
		tick(cur_a, cur_b, 1'b0, MODE_SAMPLE);
		tick(cur_a, cur_b, 1'b0, MODE_CLEAR);
		tick(cur_a, cur_b, 1'b0, MODE_SAMPLE);
	endtask

	function automatic cmd_t pick_cmd();
		int r;
		r = $urandom_range(0, 99);
		if (r < 12)
			return MODE_SAMPLE;
		if (r < 15)
			return MODE_CLEAR;
		if (r < 18)
			return MODE_REBASE;
		return MODE_NONE;
	endfunction

	function automatic logic [14:0] pick_ppr();
		case ($urandom_range(0, 5))
			0:       return 15'd0;
			1:       return 15'd1;
			2:       return 15'h7FFF;
			3:       return 15'd16384;
			default: return 15'($urandom_range(2, 40));
		endcase
	endfunction

	function automatic logic [31:0] pick_stall();
		case ($urandom_range(0, 4))
			0:       return 32'd0;
			1:       return 32'd1;
			2:       return 32'hFFFF_FFFF;
			3:       return $urandom_range(2, 60);
			default: return 32'd150000;
		endcase
	endfunction

	task automatic random_ticks();
		int   first, burst;
		bit   fwd, ix;
		cmd_t cmd;
		first = ticks_sent;
		spin_up(1'b1);
		spin_up(1'b0);
		while (ticks_sent - first < RANDOM_TICKS) begin
			configure(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), pick_ppr(),
				pick_stall());
			burst = $urandom_range(40, 120);
			fwd = 1'($urandom_range(0, 1));
			repeat (burst) begin
				if ($urandom_range(0, 19) == 0)
					fwd = !fwd;
				ix = cur_ix;
				if ($urandom_range(0, 11) == 0)
					ix = !cur_ix;
				cmd = pick_cmd();
				// mostly clean rotation, some holds, a little noise on the pins
				case ($urandom_range(0, 9))
					0:       tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), ix, cmd);
					1, 2:    tick(cur_a, cur_b, ix, cmd);
					default: step(fwd, ix, cmd);
				endcase
			end
		end
	endtask

	// Result side: stall at random, take each word and check it.
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = draw_gap(snk_calm);
			if (gap > 0) begin
				@(negedge clk);
				result_ready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk);
			result_ready <= 1'b1;
			do @(posedge clk); while (result_valid !== 1'b1);
			tracker.check_result(position_count, pulse_rate, index_found, index_offset);
		end
	end

	// Watchdog: end the run once no word has moved on either channel for too long.
	always @(posedge clk) begin
		if ((sample_valid && sample_ready) || (result_valid && result_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		directed_ticks();
		random_ticks();
		settle();
		if (tracker.miss_count == 0 && tracker.due_readouts.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
